// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: types, codes and constants.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int          OperandWidthDef = 32;
  localparam int          MaxExponentDef  = 63;
  localparam int          W64             = 64;
  localparam logic [63:0] Sign64          = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    logic [5:0]         exponent;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic signed [63:0] res_den;
    logic               overflow;
  } out_req_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLO,    // low half partial product
    ST_MHI,    // high half partial product and sum
    ST_MWB,    // sign, overflow and write back of a product
    ST_SUM,    // cross sum
    ST_PRE,    // zero check and sign move
    ST_GCD,    // Euclid remainder steps
    ST_DIVN,   // divide numerator by gcd
    ST_DIVD,   // divide denominator by gcd
    ST_DONE
  } state_t;

  // Datapath operation selector
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MLO,
    DP_MHI,
    DP_MWB,
    DP_SUM,
    DP_ZERO,
    DP_PRE,
    DP_GCD_GO,
    DP_GCD_STEP,
    DP_DIVN,
    DP_NQ,
    DP_DIVD,
    DP_DQ
  } dp_op_e;

  // Product operands and destination: dest_x_y
  typedef enum logic [2:0] {
    MS_T_AN_BD,
    MS_N_BN_AD,
    MS_N_AN_BN,
    MS_D_AD_BD,
    MS_N_N_AN,
    MS_D_D_AD
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic gcd_zero;   // gcd divisor reached zero
    logic is_zero;    // n or d zero before reduction
  } dp_stat_t;

endpackage

// ===== rtl/rau_div.sv =====
// Radix-2 unsigned 64-bit divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module rau_div
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic [63:0] q_r, q_nxt;
  logic [63:0] rm_r, rm_nxt;
  logic [63:0] dv_r, dv_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  // Shift in one dividend bit and try to subtract
  always_comb begin
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rm_r, q_r[63]} - {1'b0, dv_r};
    if (go) begin
      q_nxt    = dividend;
      rm_nxt   = '0;
      dv_nxt   = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rm_nxt = trial[63:0];
        q_nxt  = {q_r[62:0], 1'b1};
      end else begin
        rm_nxt = {rm_r[62:0], q_r[63]};
        q_nxt  = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    dv_r <= dv_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = rm_r;

endmodule

// ===== rtl/rau_datapath.sv =====
// Datapath: operand registers, multiplier, sum, sign move and gcd reduction.
`timescale 1ns / 1ps
module rau_datapath
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output out_req_t res
);

  logic [63:0] an_r, ad_r, bn_r, bd_r;
  logic [63:0] n_r, n_nxt, d_r, d_nxt, t_r, t_nxt;
  logic [63:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [63:0] plo_r, plo_nxt;
  logic [95:0] pm_r, pm_nxt;
  logic        pneg_r, pneg_nxt;
  logic        ovf_r, ovf_nxt;
  logic        sub_r;
  logic [63:0] mx, my, xm, ym;
  logic [31:0] mh;
  logic [63:0] pp, pw, s;
  logic        pov;
  logic [63:0] dvd, dvs, qv, rv;
  logic        div_go, dbusy;

  function automatic logic [63:0] sx(input logic [31:0] v);
    return {{(W64 - OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
  endfunction

  function automatic logic [63:0] mg(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // Select multiplier operands
  always_comb begin
    case (cmd.msel)
      MS_T_AN_BD: begin mx = an_r; my = bd_r; end
      MS_N_BN_AD: begin mx = bn_r; my = ad_r; end
      MS_N_AN_BN: begin mx = an_r; my = bn_r; end
      MS_D_AD_BD: begin mx = ad_r; my = bd_r; end
      MS_N_N_AN:  begin mx = n_r;  my = an_r; end
      MS_D_D_AD:  begin mx = d_r;  my = ad_r; end
      default:    begin mx = an_r; my = bd_r; end
    endcase
  end

  // Multiply magnitudes one 32-bit half of x at a time; y fits in 32 bits
  assign xm = mg(mx);
  assign ym = mg(my);
  assign mh = (cmd.op == DP_MHI) ? xm[63:32] : xm[31:0];
  assign pp = mh * ym[31:0];

  // Apply the sign and check the signed 64-bit range
  assign pw  = pneg_r ? 64'd0 - pm_r[63:0] : pm_r[63:0];
  assign pov = (pm_r[95:64] != 32'd0) || (pneg_r ? (pm_r[63:0] > Sign64) : pm_r[63]);

  rau_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go),
    .dividend(dvd),
    .divisor (dvs),
    .busy    (dbusy),
    .quot    (qv),
    .rem     (rv)
  );

  assign div_go = cmd.op inside {DP_GCD_GO, DP_DIVN, DP_DIVD};

  always_comb begin
    case (cmd.op)
      DP_DIVN: begin dvd = mg(n_r); dvs = ga_r; end
      DP_DIVD: begin dvd = mg(d_r); dvs = ga_r; end
      default: begin dvd = ga_r; dvs = gb_r; end
    endcase
  end

  // Datapath register updates
  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    t_nxt    = t_r;
    ga_nxt   = ga_r;
    gb_nxt   = gb_r;
    plo_nxt  = plo_r;
    pm_nxt   = pm_r;
    pneg_nxt = pneg_r;
    ovf_nxt  = ovf_r;
    s        = sub_r ? t_r - n_r : t_r + n_r;
    case (cmd.op)
      DP_LOAD: begin
        n_nxt   = sx(req.a_num);
        d_nxt   = sx(req.a_den);
        ovf_nxt = 1'b0;
      end
      DP_MLO: begin
        plo_nxt = pp;
      end
      DP_MHI: begin
        pm_nxt   = {pp, 32'd0} + {32'd0, plo_r};
        pneg_nxt = mx[63] ^ my[63];
      end
      DP_MWB: begin
        ovf_nxt = ovf_r | pov;
        case (cmd.msel)
          MS_T_AN_BD:            t_nxt = pw;
          MS_D_AD_BD, MS_D_D_AD: d_nxt = pw;
          default:               n_nxt = pw;
        endcase
      end
      DP_SUM: begin
        n_nxt = s;
        if (sub_r) ovf_nxt = ovf_r | ((t_r[63] != n_r[63]) && (s[63] != t_r[63]));
        else       ovf_nxt = ovf_r | ((t_r[63] == n_r[63]) && (s[63] != t_r[63]));
      end
      DP_ZERO: begin
        n_nxt = 64'd0;
        d_nxt = 64'd1;
      end
      DP_PRE: begin
        // Move the sign to the numerator; magnitudes are unchanged by it
        if (d_r[63]) begin
          if (d_r == Sign64 || n_r == Sign64)
            ovf_nxt = 1'b1;
          n_nxt = 64'd0 - n_r;
          d_nxt = 64'd0 - d_r;
        end
        ga_nxt = mg(n_r);
        gb_nxt = mg(d_r);
      end
      DP_GCD_STEP: begin
        ga_nxt = gb_r;
        gb_nxt = rv;
      end
      DP_NQ: begin
        n_nxt = n_r[63] ? 64'd0 - qv : qv;
      end
      DP_DQ: begin
        d_nxt = d_r[63] ? 64'd0 - qv : qv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    t_r    <= t_nxt;
    ga_r   <= ga_nxt;
    gb_r   <= gb_nxt;
    plo_r  <= plo_nxt;
    pm_r   <= pm_nxt;
    pneg_r <= pneg_nxt;
    // Capture operands; divide swaps the second fraction to reuse multiply
    if (cmd.op == DP_LOAD) begin
      an_r  <= sx(req.a_num);
      ad_r  <= sx(req.a_den);
      sub_r <= (req.cmd == CMD_SUB);
      if (req.cmd == CMD_DIV) begin
        bn_r <= sx(req.b_den);
        bd_r <= sx(req.b_num);
      end else begin
        bn_r <= sx(req.b_num);
        bd_r <= sx(req.b_den);
      end
    end
  end

  assign stat.div_busy = dbusy;
  assign stat.gcd_zero = (gb_r == 64'd0);
  assign stat.is_zero  = (n_r == 64'd0) || (d_r == 64'd0);

  assign res.res_num  = n_r;
  assign res.res_den  = d_r;
  assign res.overflow = ovf_r;

endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller: sequences multiply, sum, sign move and gcd reduction steps.
`timescale 1ns / 1ps
module rau_ctrl
  import rau_pkg::*;
#(
  parameter int MAX_EXPONENT = MaxExponentDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_req_t  req,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done,
  output logic     unk
);

  state_t     st_r, st_nxt;
  logic [2:0] op_r, op_nxt;
  logic [7:0] e_r, e_nxt;
  logic [1:0] pk_r, pk_nxt;
  logic       wait_r, wait_nxt;
  logic [7:0] e_sat;
  mul_sel_e   msel;
  logic       mlast;
  logic       more_pow;

  assign e_sat = ({2'b00, req.exponent} > 8'(MAX_EXPONENT)) ? 8'(MAX_EXPONENT)
               : {2'b00, req.exponent};

  // Another power step follows the current reduction
  assign more_pow = (op_r == CMD_POW) && (e_r > 8'd2);

  // Pick the product for the current step
  always_comb begin
    msel  = MS_T_AN_BD;
    mlast = 1'b0;
    case (op_r)
      CMD_ADD, CMD_SUB: begin
        case (pk_r)
          2'd0:    msel = MS_T_AN_BD;
          2'd1:    msel = MS_N_BN_AD;
          default: begin
            msel  = MS_D_AD_BD;
            mlast = 1'b1;
          end
        endcase
      end
      CMD_POW: begin
        msel  = (pk_r == 2'd0) ? MS_N_N_AN : MS_D_D_AD;
        mlast = (pk_r != 2'd0);
      end
      default: begin
        msel  = (pk_r == 2'd0) ? MS_N_AN_BN : MS_D_AD_BD;
        mlast = (pk_r != 2'd0);
      end
    endcase
  end

  // Next state
  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    e_nxt    = e_r;
    pk_nxt   = pk_r;
    wait_nxt = wait_r;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = req.cmd;
          e_nxt    = e_sat;
          pk_nxt   = 2'd0;
          wait_nxt = 1'b0;
          if (req.cmd == CMD_POW)
            st_nxt = (e_sat <= 8'd1) ? ST_DONE : ST_MLO;
          else if (req.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV})
            st_nxt = ST_MLO;
          else
            st_nxt = ST_DONE;
        end
      end
      ST_MLO: st_nxt = ST_MHI;
      ST_MHI: st_nxt = ST_MWB;
      ST_MWB: begin
        if (!mlast) begin
          pk_nxt = pk_r + 2'd1;
          st_nxt = ST_MLO;
        end else if (op_r == CMD_ADD || op_r == CMD_SUB) begin
          st_nxt = ST_SUM;
        end else begin
          st_nxt = ST_PRE;
        end
      end
      ST_SUM: st_nxt = ST_PRE;
      ST_PRE: begin
        wait_nxt = 1'b0;
        if (!stat.is_zero) begin
          st_nxt = ST_GCD;
        end else if (more_pow) begin
          e_nxt  = e_r - 8'd1;
          pk_nxt = 2'd0;
          st_nxt = ST_MLO;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_GCD: begin
        if (!wait_r) begin
          if (stat.gcd_zero) st_nxt = ST_DIVN;
          else wait_nxt = 1'b1;
        end else if (!stat.div_busy) begin
          wait_nxt = 1'b0;
        end
      end
      ST_DIVN: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (!stat.div_busy) begin
          wait_nxt = 1'b0;
          st_nxt   = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (!stat.div_busy) begin
          wait_nxt = 1'b0;
          if (more_pow) begin
            e_nxt  = e_r - 8'd1;
            pk_nxt = 2'd0;
            st_nxt = ST_MLO;
          end else begin
            st_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op   = DP_NOP;
    cmd.msel = msel;
    case (st_r)
      ST_IDLE: if (start) cmd.op = DP_LOAD;
      ST_MLO:  cmd.op = DP_MLO;
      ST_MHI:  cmd.op = DP_MHI;
      ST_MWB:  cmd.op = DP_MWB;
      ST_SUM:  cmd.op = DP_SUM;
      ST_PRE:  cmd.op = stat.is_zero ? DP_ZERO : DP_PRE;
      ST_GCD: begin
        if (!wait_r) begin
          if (!stat.gcd_zero) cmd.op = DP_GCD_GO;
        end else if (!stat.div_busy) begin
          cmd.op = DP_GCD_STEP;
        end
      end
      ST_DIVN: begin
        if (!wait_r) cmd.op = DP_DIVN;
        else if (!stat.div_busy) cmd.op = DP_NQ;
      end
      ST_DIVD: begin
        if (!wait_r) cmd.op = DP_DIVD;
        else if (!stat.div_busy) cmd.op = DP_DQ;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      wait_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
    op_r <= op_nxt;
    e_r  <= e_nxt;
    pk_r <= pk_nxt;
  end

  assign busy = (st_r != ST_IDLE);
  assign done = (st_r == ST_DONE);
  assign unk  = !(op_r == CMD_ADD || op_r == CMD_SUB || op_r == CMD_MUL
                  || op_r == CMD_DIV || op_r == CMD_POW);

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: fraction add/sub/mul/div/power with gcd reduction.
//
// Usage: raise start with a request on in_req while busy is low; the request
// is taken at that edge and busy rises the next cycle. One result appears on
// out_res for exactly one cycle, marked by out_valid; the receiver cannot
// hold it off. busy drops the cycle after the result, so a new request is
// taken in the cycle after the result at the earliest.
// Sequence: each product runs through the MLO, MHI and MWB states on one
// 32x32 multiplier; add/sub form three products and a sum, mul/div two
// products, before reduction. Reduction runs one sign-move step, then
// Euclid steps on the one-bit-a-cycle 64-bit divider plus a step to see the
// zero remainder, then two quotients, numerator and denominator. A zero
// numerator or denominator skips the gcd. Power runs two products and a
// reduction per exponent step. Power with exponent 0 or 1 and unknown
// operations go straight to the result.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// any request in progress.
`timescale 1ns / 1ps
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = OperandWidthDef,
  parameter int MAX_EXPONENT  = MaxExponentDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_req_t out_res
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  out_req_t dres;
  logic     done, unk;

  rau_ctrl #(.MAX_EXPONENT(MAX_EXPONENT)) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .req  (in_req),
    .stat (dstat),
    .cmd  (dcmd),
    .busy (busy),
    .done (done),
    .unk  (unk)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (in_req),
    .cmd  (dcmd),
    .stat (dstat),
    .res  (dres)
  );

  // Force 0/1 for unknown operations
  always_comb begin
    out_res = dres;
    if (unk) begin
      out_res.res_num  = 64'sd0;
      out_res.res_den  = 64'sd1;
      out_res.overflow = 1'b0;
    end
  end
  assign out_valid = done;

endmodule

// ===== verif/rational_arithmetic_unit_test.sv =====
// Testbench for the rational arithmetic unit: random and directed fraction requests.
`timescale 1ns / 1ps
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  typedef bit [63:0] u64_t;

  localparam int   NumRandom  = 1900;
  localparam int   DrainWait  = 20;
  localparam int   StallLimit = 2000000;
  localparam u64_t MinS64     = 64'h8000_0000_0000_0000;

  // Hold expected fractions in request order and compare each result.
  class fraction_scoreboard;
    out_req_t pending[$];
    int       errors;

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void note(out_req_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check(out_req_t got);
      out_req_t exp_res;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d", got.res_num, got.res_den));
        return;
      end
      exp_res = pending.pop_front();
      if (got.res_num !== exp_res.res_num)
        report($sformatf("res_num %0d, want %0d", got.res_num, exp_res.res_num));
      if (got.res_den !== exp_res.res_den)
        report($sformatf("res_den %0d, want %0d", got.res_den, exp_res.res_den));
      if (got.overflow !== exp_res.overflow)
        report($sformatf("overflow %0b, want %0b", got.overflow, exp_res.overflow));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_req_t out_res;

  fraction_scoreboard sb;
  int unsigned        taken_cnt;
  int unsigned        idle_pct;

  rational_arithmetic_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Signed 64-bit arithmetic with wrap and overflow detection.
  function automatic u64_t abs64(u64_t x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic u64_t mul64(u64_t x, u64_t y, inout bit ovf);
    bit [127:0] prod;
    prod = {64'd0, abs64(x)} * {64'd0, abs64(y)};
    if (prod[127:64] != 64'd0) ovf = 1'b1;
    else if (prod[63:0] > ((x[63] ^ y[63]) ? MinS64 : MinS64 - 64'd1)) ovf = 1'b1;
    return x * y;
  endfunction

  function automatic u64_t add64(u64_t x, u64_t y, inout bit ovf);
    u64_t s;
    s = x + y;
    if (x[63] == y[63] && s[63] != x[63]) ovf = 1'b1;
    return s;
  endfunction

  function automatic u64_t sub64(u64_t x, u64_t y, inout bit ovf);
    u64_t s;
    s = x - y;
    if (x[63] != y[63] && s[63] != x[63]) ovf = 1'b1;
    return s;
  endfunction

  // Normalize sign, then divide out the Euclidean gcd.
  function automatic void reduce_frac(inout u64_t n, inout u64_t d, inout bit ovf);
    u64_t mn, md, ga, gb, r;
    if (n == 0 || d == 0) begin
      n = 64'd0;
      d = 64'd1;
      return;
    end
    if (d[63]) begin
      if (d == MinS64 || n == MinS64) ovf = 1'b1;
      n = 64'd0 - n;
      d = 64'd0 - d;
    end
    mn = abs64(n);
    md = abs64(d);
    ga = mn;
    gb = md;
    while (gb != 0) begin
      r  = ga % gb;
      ga = gb;
      gb = r;
    end
    if (ga == 0) ga = 64'd1;
    n = n[63] ? 64'd0 - (mn / ga) : mn / ga;
    d = d[63] ? 64'd0 - (md / ga) : md / ga;
  endfunction

  function automatic out_req_t predict_fraction(in_req_t r);
    out_req_t res;
    u64_t     an, ad, bn, bd, n, d;
    bit       ovf;
    int       e;
    an  = u64_t'(64'(r.a_num));
    ad  = u64_t'(64'(r.a_den));
    bn  = u64_t'(64'(r.b_num));
    bd  = u64_t'(64'(r.b_den));
    n   = 64'd0;
    d   = 64'd1;
    ovf = 1'b0;
    case (r.cmd)
      CMD_ADD, CMD_SUB: begin
        n = (r.cmd == CMD_ADD) ?
            add64(mul64(an, bd, ovf), mul64(bn, ad, ovf), ovf) :
            sub64(mul64(an, bd, ovf), mul64(bn, ad, ovf), ovf);
        d = mul64(ad, bd, ovf);
        reduce_frac(n, d, ovf);
      end
      CMD_MUL: begin
        n = mul64(an, bn, ovf);
        d = mul64(ad, bd, ovf);
        reduce_frac(n, d, ovf);
      end
      CMD_DIV: begin
        n = mul64(an, bd, ovf);
        d = mul64(ad, bn, ovf);
        reduce_frac(n, d, ovf);
      end
      CMD_POW: begin
        e = (r.exponent > MaxExponentDef) ? MaxExponentDef : int'(r.exponent);
        n = an;
        d = ad;
        for (int i = 1; i < e; i++) begin
          n = mul64(n, an, ovf);
          d = mul64(d, ad, ovf);
          reduce_frac(n, d, ovf);
        end
      end
      default: ;
    endcase
    res.res_num  = n;
    res.res_den  = d;
    res.overflow = ovf;
    return res;
  endfunction

  // Drive one request, with random idle cycles ahead of it.
  task automatic send_req(in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start  = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    sb.note(predict_fraction(r));
    taken_cnt++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_fields(logic [2:0] cmd, int an, int ad, int bn, int bd,
                             logic [5:0] e);
    in_req_t r;
    r.cmd      = cmd;
    r.a_num    = an;
    r.a_den    = ad;
    r.b_num    = bn;
    r.b_den    = bd;
    r.exponent = e;
    send_req(r);
  endtask

  // Mix zeros, small, medium and full-range operands.
  function automatic int pick_operand();
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1, 2:    v = int'($urandom_range(40)) - 20;
      3, 4:    v = int'($urandom_range(131070)) - 65535;
      5: begin
        case ($urandom_range(3))
          0:       v = 2147483647;
          1:       v = -2147483647;
          2:       v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = int'($urandom);
        if (v == 32'sh8000_0000) v = -2147483647;
      end
    endcase
    return v;
  endfunction

  // Check every result in the cycle it is presented.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check(out_res);
      taken_cnt++;
    end
  end

  // End the run if nothing moves for too long.
  initial begin
    int unsigned last_cnt;
    int          stall;
    last_cnt = 0;
    stall    = 0;
    forever begin
      @(posedge clk);
      if (taken_cnt != last_cnt) begin
        last_cnt = taken_cnt;
        stall    = 0;
      end else if (++stall >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("** rational_arithmetic_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] cmd;
    logic [5:0] e;
    sb        = new();
    taken_cnt = 0;
    idle_pct  = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Extremes, each operation, zero and negative denominators.
    send_fields(CMD_ADD, 2147483647, 2147483647, 2147483647, 2147483647, 6'd0);
    send_fields(CMD_ADD, -2147483647, 3, -2147483647, -7, 6'd63);
    send_fields(CMD_SUB, 1, 2, 1, 2, 6'd0);
    send_fields(CMD_SUB, 2147483647, -1, -2147483647, 1, 6'd0);
    send_fields(CMD_MUL, -2147483647, -2147483647, 2147483647, -2147483647, 6'd0);
    send_fields(CMD_MUL, 6, -4, 10, 9, 6'd0);
    send_fields(CMD_DIV, 3, 4, 0, 5, 6'd0);
    send_fields(CMD_DIV, -8, 3, -2, -9, 6'd0);
    send_fields(CMD_ADD, 5, 0, 1, 3, 6'd0);
    send_fields(CMD_MUL, 0, 7, 4, 9, 6'd0);
    send_fields(CMD_POW, -5, 0, 0, 0, 6'd0);
    send_fields(CMD_POW, 7, -3, 0, 0, 6'd1);
    send_fields(CMD_POW, 2, -3, 0, 0, 6'd2);
    send_fields(CMD_POW, 1, -2, 0, 0, 6'd63);
    send_fields(CMD_POW, -2, 1, 0, 0, 6'd63);
    send_fields(CMD_POW, 2147483647, 2, 0, 0, 6'd3);
    send_fields(3'd5, 1, 1, 1, 1, 6'd5);
    send_fields(3'd7, -1, -1, -1, -1, 6'd63);
    send_fields(CMD_SUB, 4, 6, 2, 3, 6'd0);

    // Random requests over several idle phases.
    for (int k = 0; k < NumRandom; k++) begin
      case (k / (NumRandom / 4))
        0:       idle_pct = 0;
        1:       idle_pct = 86;
        2:       idle_pct = 34;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(49) == 0) cmd = 3'($urandom_range(7, 5));
      else cmd = 3'($urandom_range(4));
      // Keep long power chains rare; they cost one reduction per step.
      if ($urandom_range(99) < 2) e = 6'($urandom_range(63));
      else e = 6'($urandom_range(6));
      send_fields(cmd, pick_operand(), pick_operand(), pick_operand(),
                  pick_operand(), e);
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    if (sb.errors == 0) begin
      $display("** rational_arithmetic_unit: PASSED **");
    end else begin
      $display("** rational_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule
